/* design/dks_pkg.sv */
// Shared types, tables and subkey function for the DES subkey schedule.
package dks_pkg;

    localparam int HALF_BITS  = 28;
    localparam int JOIN_BITS  = 56;
    localparam int KEY_BITS   = 48;
    localparam int ROUNDS     = 16;
    localparam int ROUND_BITS = 4;
    localparam int SHIFT_BITS = 5;
    localparam int SEL_BITS   = 6;

    localparam logic [ROUND_BITS-1:0] LAST_ROUND = ROUND_BITS'(ROUNDS - 1);

    // Accumulated left rotation of each half after each round (1,1,2,2,2,2,2,2,1,2,...).
    localparam logic [SHIFT_BITS-1:0] ROT_TOTAL [ROUNDS] = '{
        5'd1,  5'd2,  5'd4,  5'd6,  5'd8,  5'd10, 5'd12, 5'd14,
        5'd15, 5'd17, 5'd19, 5'd21, 5'd23, 5'd25, 5'd27, 5'd28
    };

    // PC-2 selection, bit 1 = MSB of C:D.
    localparam logic [SEL_BITS-1:0] PC2_SEL [KEY_BITS] = '{
        6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,  6'd3,  6'd28,
        6'd15, 6'd6,  6'd21, 6'd10, 6'd23, 6'd19, 6'd12, 6'd4,
        6'd26, 6'd8,  6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
        6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55, 6'd30, 6'd40,
        6'd51, 6'd45, 6'd33, 6'd48, 6'd44, 6'd49, 6'd39, 6'd56,
        6'd34, 6'd53, 6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
    };

    // One word held in a chain cell.
    typedef struct packed {
        logic                  valid;
        logic                  last;
        logic [ROUND_BITS-1:0] round;
        logic [KEY_BITS-1:0]   key;
    } dks_word_t;

    function automatic logic [HALF_BITS-1:0] dks_rotl(input logic [HALF_BITS-1:0] v,
                                                      input logic [SHIFT_BITS-1:0] amt);
        logic [2*HALF_BITS-1:0] dbl;
        dbl = {v, v} >> (SHIFT_BITS'(HALF_BITS) - amt);
        return dbl[HALF_BITS-1:0];
    endfunction

    // Subkey of one round; called with a constant round, so it reduces to wiring.
    function automatic logic [KEY_BITS-1:0] dks_subkey(input logic [HALF_BITS-1:0] c,
                                                       input logic [HALF_BITS-1:0] d,
                                                       input logic [ROUND_BITS-1:0] rnd);
        logic [JOIN_BITS-1:0] cd;
        logic [KEY_BITS-1:0]  k;
        cd = {dks_rotl(c, ROT_TOTAL[rnd]), dks_rotl(d, ROT_TOTAL[rnd])};
        k  = '0;
        for (int i = 0; i < KEY_BITS; i++) begin
            k[KEY_BITS-1-i] = cd[JOIN_BITS - int'(PC2_SEL[i])];
        end
        return k;
    endfunction

endpackage

/* design/dks_cell.sv */
// One cell of the subkey shift chain: loads its round's subkey or takes its neighbor's.
module dks_cell import dks_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      load,
    input  logic      shift,
    input  dks_word_t load_word,
    input  dks_word_t next_word,
    output dks_word_t word
);

    dks_word_t word_reg;
    dks_word_t word_next;

    always_comb begin
        word_next = word_reg;
        if (load) begin
            word_next = load_word;
        end else if (shift) begin
            word_next = next_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_reg.valid <= 1'b0;
        end else begin
            word_reg <= word_next;
        end
    end

    assign word = word_reg;

endmodule

/* design/des_subkey_schedule.sv */
// DES subkey schedule top level: input buffer and sixteen-cell output chain.
//
// Input channel s_*: one word carries the key halves C0 and D0 after PC-1.
// Result channel m_*: each input word yields sixteen subkey words, K1 first,
// with m_tlast high on K16.
// Inside, all sixteen rotated-and-compressed subkeys are plain wiring from
// the buffered halves; they load in parallel into a row of sixteen cells,
// and the row shifts one cell toward the output each time a word is taken.
// With the chain idle, an accepted input word is registered in the input
// buffer and then loaded into the cells, where m_tvalid rises with K1.
// Each input yields sixteen subkey words on the single result channel;
// a buffered input loads in the same cycle the last subkey of the
// previous run is taken, so runs follow with no gap.
// A one-word input buffer takes the next key while a run is still going out.
// When m_tready is low the chain holds and the buffered input waits.
// Reset (aresetn low, synchronous) empties the buffer and every cell.
module des_subkey_schedule import dks_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // [27:0] c_half, [55:28] d_half
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [3:0] round_index, [51:4] subkey, [55:52] zero
    output logic        m_tlast    // last_key
);

    logic                 in_valid_reg;
    logic                 in_valid_next;
    logic [HALF_BITS-1:0] c_reg;
    logic [HALF_BITS-1:0] d_reg;
    logic                 load;
    logic                 shift;
    dks_word_t            head;
    dks_word_t            cell_word [ROUNDS];
    dks_word_t            load_word [ROUNDS];

    assign head  = cell_word[0];
    assign shift = head.valid && m_tready;
    // chain is compact, so an idle head means all cells are empty
    assign load  = in_valid_reg && (!head.valid || (head.last && m_tready));

    assign s_tready = !in_valid_reg || load;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (load) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            c_reg <= s_tdata[HALF_BITS-1:0];
            d_reg <= s_tdata[2*HALF_BITS-1:HALF_BITS];
        end
    end

    for (genvar k = 0; k < ROUNDS; k++) begin : g_cell
        dks_word_t neighbor;

        assign load_word[k].valid = 1'b1;
        assign load_word[k].last  = (k == ROUNDS - 1);
        assign load_word[k].round = ROUND_BITS'(k);
        assign load_word[k].key   = dks_subkey(c_reg, d_reg, ROUND_BITS'(k));

        if (k == ROUNDS - 1) begin : g_tail
            assign neighbor = '0;
        end else begin : g_mid
            assign neighbor = cell_word[k+1];
        end

        dks_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .load      (load),
            .shift     (shift),
            .load_word (load_word[k]),
            .next_word (neighbor),
            .word      (cell_word[k])
        );
    end

    assign m_tvalid = head.valid;
    assign m_tdata  = {4'b0000, head.key, head.round};
    assign m_tlast  = head.last;

    a_last_on_final_round : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (head.round == LAST_ROUND)))
        else $error("tlast not on final round");

    a_round_advances : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=>
            (m_tvalid && head.round == $past(head.round) + 1'b1))
        else $error("subkey run broken");

    a_chain_compact : assert property (@(posedge aclk) disable iff (!aresetn)
        (head.valid && !head.last) |-> cell_word[1].valid)
        else $error("gap in subkey chain");

    a_load_when_free : assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> (m_tvalid && head.round == '0))
        else $error("load did not start a run");

endmodule

/* tb/dks_checker.sv */
// Checker for the DES subkey schedule: predicts all sixteen subkeys of each key word and compares.
`timescale 1ns / 100ps

module dks_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [55:0] s_tdata,   // [27:0] c_half, [55:28] d_half
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,   // [3:0] round_index, [51:4] subkey, [55:52] zero
    input  logic        m_tlast,   // last_key
    output int          mismatches,
    output int          pending_words
);

    // Bit r set: round r rotates both halves by two, else by one.
    localparam logic [15:0] DOUBLE_ROT = 16'b0111111011111100;

    // PC-2 pick list, entry 0 in the top six bits; 1 = MSB of C:D.
    localparam logic [6*48-1:0] PC2_PICK = {
        6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,  6'd3,  6'd28,
        6'd15, 6'd6,  6'd21, 6'd10, 6'd23, 6'd19, 6'd12, 6'd4,
        6'd26, 6'd8,  6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
        6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55, 6'd30, 6'd40,
        6'd51, 6'd45, 6'd33, 6'd48, 6'd44, 6'd49, 6'd39, 6'd56,
        6'd34, 6'd53, 6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
    };

    typedef struct packed {
        logic [3:0]  round;
        logic [47:0] key;
        logic        last;
    } subkey_word_t;

    subkey_word_t subkeys_due[$];

    initial begin
        mismatches    = 0;
        pending_words = 0;
    end

    function automatic logic [27:0] rotate_half(input logic [27:0] v, input logic twice);
        return twice ? {v[25:0], v[27:26]} : {v[26:0], v[27]};
    endfunction

    function automatic logic [47:0] compress_pc2(input logic [55:0] cd);
        logic [47:0] k;
        logic [5:0]  sel;
        k = '0;
        for (int i = 0; i < 48; i++) begin
            sel       = PC2_PICK[6*(47-i) +: 6];
            k[47-i]   = cd[56 - int'(sel)];
        end
        return k;
    endfunction

    function automatic void queue_round_keys(input logic [27:0] c0, input logic [27:0] d0);
        logic [27:0]  c;
        logic [27:0]  d;
        subkey_word_t w;
        c = c0;
        d = d0;
        for (int r = 0; r < 16; r++) begin
            c       = rotate_half(c, DOUBLE_ROT[r]);
            d       = rotate_half(d, DOUBLE_ROT[r]);
            w.round = 4'(r);
            w.key   = compress_pc2({c, d});
            w.last  = (r == 15);
            subkeys_due.push_back(w);
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        subkey_word_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                queue_round_keys(s_tdata[27:0], s_tdata[55:28]);
            end
            if (m_tvalid && m_tready) begin
                if (subkeys_due.size() == 0) begin
                    report_mismatch("unexpected subkey word", 64'(m_tdata), 64'd0);
                end else begin
                    want = subkeys_due.pop_front();
                    if (m_tdata[3:0] != want.round)
                        report_mismatch("round_index", 64'(m_tdata[3:0]), 64'(want.round));
                    if (m_tdata[51:4] != want.key)
                        report_mismatch("subkey", 64'(m_tdata[51:4]), 64'(want.key));
                    if (m_tlast != want.last)
                        report_mismatch("last_key", 64'(m_tlast), 64'(want.last));
                end
            end
            pending_words <= subkeys_due.size();
        end
    end

endmodule

/* tb/testbench.sv */
// Testbench top for the DES subkey schedule: clock, reset, key stimulus and verdict.
`timescale 1ns / 100ps

module testbench;

    localparam int IDLE_LIMIT   = 5000;
    localparam int KEYS_PER_SET = 30;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic        m_tlast;

    int mismatches;
    int pending_words;
    int send_idle  = 0;
    int recv_stall = 0;
    int idle_cycles = 0;

    des_subkey_schedule i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    dks_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .mismatches    (mismatches),
        .pending_words (pending_words)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Holds tvalid high across back-to-back words; only an idle gap or drain_results lowers it.
    task automatic send_key(input logic [27:0] c, input logic [27:0] d);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 56'({$urandom, $urandom});
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {d, c};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    function automatic logic [27:0] random_half();
        logic [27:0] v;
        case ($urandom_range(3))
            0: v = 28'd1 << $urandom_range(27);
            1: v = ~(28'd1 << $urandom_range(27));
            default: v = 28'($urandom);
        endcase
        return v;
    endfunction

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_words != 0) @(posedge aclk);
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // edge patterns with no idling
        send_key(28'h0000000, 28'h0000000);
        send_key(28'hFFFFFFF, 28'hFFFFFFF);
        send_key(28'hFFFFFFF, 28'h0000000);
        send_key(28'h0000000, 28'hFFFFFFF);
        send_key(28'hAAAAAAA, 28'h5555555);
        send_key(28'h5555555, 28'hAAAAAAA);
        send_key(28'h8000000, 28'h0000000);
        send_key(28'h0000001, 28'h0000000);
        send_key(28'h0000000, 28'h8000000);
        send_key(28'h0000000, 28'h0000001);
        send_key(28'hC000003, 28'h3FFFFFC);
        send_key(28'h1234567, 28'h89ABCDE);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 59; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 59; end
                default: begin send_idle = 35; recv_stall = 35; end
            endcase
            for (int n = 0; n < KEYS_PER_SET; n++) begin
                send_key(random_half(), random_half());
            end
            // hold the sender off until every subkey of the set is out
            drain_results();
        end

        send_idle  = 0;
        recv_stall = 0;
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && pending_words == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

/* sim.f */
design/dks_pkg.sv
design/dks_cell.sv
design/des_subkey_schedule.sv
tb/dks_checker.sv
tb/testbench.sv
